// File: sv/pdq_pkg.sv
package pdq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned RunSlotsDef   = 16;
  localparam int unsigned NumAgentsDef  = 16;
  localparam int unsigned MaxDispatch   = 16;

  typedef enum logic [2:0] {
    CMD_SUBMIT   = 3'd0,
    CMD_COMPLETE = 3'd1,
    CMD_CANCEL   = 3'd2,
    CMD_PAUSE    = 3'd3,
    CMD_RESUME   = 3'd4,
    CMD_STATUS   = 3'd5
  } cmd_e;

  localparam logic [1:0] KIND_REPLY    = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_REJECT   = 2'd2;

  localparam logic [0:0] CFG_MAX_RUNNING   = 1'b0;
  localparam logic [0:0] CFG_MAX_PER_AGENT = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] task_ref;
    logic [3:0]  agent;
    logic [1:0]  prio;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_task;
    logic [3:0]  out_agent;
    logic        found;
    logic        paused_now;
    logic [4:0]  queued_count;
    logic [4:0]  running_count;
    logic [4:0]  agent_running;
    logic        last;
  } result_t;

  // decoded command handed from front to back
  typedef struct packed {
    cmd_e        op;
    logic [15:0] task_ref;
    logic [3:0]  agent;
    logic [1:0]  prio;
  } cmd_t;

  typedef struct packed {
    logic [4:0] max_running;
    logic [4:0] max_per_agent;
  } cfg_t;

  function automatic logic [4:0] sat5(input logic [15:0] v);
    logic [4:0] r;
    r = (v > 16'd31) ? 5'd31 : v[4:0];
    return r;
  endfunction

endpackage

// File: sv/pdq_front.sv
module pdq_front
  import pdq_pkg::*;
#(
  parameter int unsigned NUM_AGENTS = NumAgentsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  item_t item_i,
  input  logic  deq_i,
  output logic  avail_o,
  output cmd_t  cmd_o
);

  logic [3:0] agent_map [16];
  cmd_t       dec;
  cmd_t       buf_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       enq;

  for (genvar g = 0; g < 16; g++) begin : g_amap
    assign agent_map[g] = 4'(g % NUM_AGENTS);
  end

  always_comb begin
    dec.task_ref = item_i.task_ref;
    dec.agent    = agent_map[item_i.agent];
    dec.prio     = item_i.prio;
    case (item_i.command)
      CMD_SUBMIT:   dec.op = CMD_SUBMIT;
      CMD_COMPLETE: dec.op = CMD_COMPLETE;
      CMD_CANCEL:   dec.op = CMD_CANCEL;
      CMD_PAUSE:    dec.op = CMD_PAUSE;
      CMD_RESUME:   dec.op = CMD_RESUME;
      default:      dec.op = CMD_STATUS; // unknown codes only reply
    endcase
  end

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign cmd_o   = buf_q[rd_ptr_q];
  assign enq     = push_i && !full_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (deq_i && avail_o) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (enq && !(deq_i && avail_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!enq && deq_i && avail_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      buf_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: sv/pdq_rfifo.sv
module pdq_rfifo
  import pdq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t data_o
);

  result_t    buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = buf_q[rd_ptr_q];
  assign wr      = wr_i && !full_o;
  assign rd      = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!wr && rd) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr ? !wr_ptr_q : wr_ptr_q;
      rd_ptr_q <= rd ? !rd_ptr_q : rd_ptr_q;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: sv/pdq_back.sv
module pdq_back
  import pdq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned RUN_SLOTS   = RunSlotsDef,
  parameter int unsigned NUM_AGENTS  = NumAgentsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    avail_i,
  input  cmd_t    cmd_i,
  output logic    deq_o,
  output logic    res_wr_o,
  output result_t res_o,
  input  logic    res_full_i
);

  localparam int unsigned QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RIW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
  localparam int unsigned RCW = $clog2(RUN_SLOTS + 1);
  localparam int unsigned AW  = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
  localparam int unsigned DCW = $clog2(MaxDispatch + 1);

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  agent;
    logic [1:0]  prio;
  } pend_t;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_EXEC   = 16'h0002,
    ST_PS_RD  = 16'h0004,
    ST_PS_CMP = 16'h0008,
    ST_RS_RD  = 16'h0010,
    ST_RS_CMP = 16'h0020,
    ST_CL_A   = 16'h0040,
    ST_CL_B   = 16'h0080,
    ST_DS_RD  = 16'h0100,
    ST_DS_CMP = 16'h0200,
    ST_DL_A   = 16'h0400,
    ST_DL_B   = 16'h0800,
    ST_RL_A   = 16'h1000,
    ST_RL_B   = 16'h2000
  } state_e;

  state_e state_q, state_d;

  // memories
  pend_t       pend_mem [QUEUE_DEPTH];
  logic [15:0] run_mem  [RUN_SLOTS];
  logic [4:0]  ld_mem   [NUM_AGENTS];
  pend_t       pd_rd_q;
  logic [15:0] rm_rd_q;
  logic [4:0]  ld_rd_q;
  logic        ld_vrd_q;

  logic              pd_we;
  logic [QIW-1:0]    pd_waddr;
  pend_t             pd_wdata;
  logic              rm_we;
  logic [RIW-1:0]    rm_waddr;
  logic              ld_we;
  logic [4:0]        ld_wdata;

  logic [QUEUE_DEPTH-1:0] pend_vld_q, pend_vld_d;
  logic [RUN_SLOTS-1:0]   run_vld_q, run_vld_d;
  logic [NUM_AGENTS-1:0]  ld_vld_q, ld_vld_d;

  logic [QCW-1:0] pend_cnt_q, pend_cnt_d;
  logic [RCW-1:0] run_cnt_q, run_cnt_d;
  logic [15:0]    next_id_q, next_id_d;
  logic           pause_q, pause_d;
  cmd_t           cmd_q, cmd_d;
  logic [1:0]     kind_q, kind_d;
  logic [15:0]    task_q, task_d;
  logic           found_q, found_d;
  logic [QCW-1:0] scan_q, scan_d;
  logic [RCW-1:0] rscan_q, rscan_d;
  logic [AW-1:0]  ld_addr_q, ld_addr_d;
  logic [DCW-1:0] ndisp_q, ndisp_d;
  logic           best_vld_q, best_vld_d;
  logic [QIW-1:0] best_idx_q, best_idx_d;
  pend_t          best_q, best_d;
  logic [15:0]    best_age_q, best_age_d;

  logic [QIW-1:0] pfree;
  logic [RIW-1:0] rfree;
  logic [15:0]    age;
  logic [4:0]     load;
  logic           start_disp;

  always_comb begin
    pfree = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!pend_vld_q[i]) begin
        pfree = QIW'(i);
      end
    end
    rfree = '0;
    for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
      if (!run_vld_q[i]) begin
        rfree = RIW'(i);
      end
    end
  end

  assign age  = next_id_q - pd_rd_q.id;
  assign load = ld_vrd_q ? ld_rd_q : 5'd0;

  always_comb begin
    state_d    = state_q;
    pend_vld_d = pend_vld_q;
    run_vld_d  = run_vld_q;
    ld_vld_d   = ld_vld_q;
    pend_cnt_d = pend_cnt_q;
    run_cnt_d  = run_cnt_q;
    next_id_d  = next_id_q;
    pause_d    = pause_q;
    cmd_d      = cmd_q;
    kind_d     = kind_q;
    task_d     = task_q;
    found_d    = found_q;
    scan_d     = scan_q;
    rscan_d    = rscan_q;
    ld_addr_d  = ld_addr_q;
    ndisp_d    = ndisp_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    best_age_d = best_age_q;
    pd_we      = 1'b0;
    pd_waddr   = pfree;
    pd_wdata   = '0;
    rm_we      = 1'b0;
    rm_waddr   = rfree;
    ld_we      = 1'b0;
    ld_wdata   = '0;
    deq_o      = 1'b0;
    res_wr_o   = 1'b0;
    res_o      = '0;
    start_disp = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (avail_i) begin
          deq_o   = 1'b1;
          cmd_d   = cmd_i;
          kind_d  = KIND_REPLY;
          task_d  = '0;
          found_d = 1'b0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_q.op)
          CMD_SUBMIT: begin
            if (32'(pend_cnt_q) == QUEUE_DEPTH) begin
              kind_d = KIND_REJECT;
            end else begin
              pd_we             = 1'b1;
              pd_wdata.id       = next_id_q;
              pd_wdata.agent    = cmd_q.agent;
              pd_wdata.prio     = cmd_q.prio;
              pend_vld_d[pfree] = 1'b1;
              pend_cnt_d        = pend_cnt_q + 1'b1;
              task_d            = next_id_q;
              next_id_d         = next_id_q + 16'd1;
            end
            start_disp = 1'b1;
          end
          CMD_COMPLETE: begin
            rscan_d = '0;
            state_d = ST_RS_RD;
          end
          CMD_CANCEL: begin
            scan_d  = '0;
            state_d = ST_PS_RD;
          end
          CMD_PAUSE: begin
            pause_d = 1'b1;
            state_d = ST_RL_A;
          end
          CMD_RESUME: begin
            pause_d    = 1'b0;
            start_disp = 1'b1;
          end
          default: begin
            state_d = ST_RL_A;
          end
        endcase
      end
      ST_PS_RD: begin
        if (32'(scan_q) == QUEUE_DEPTH) begin
          state_d = ST_RL_A;
        end else if (pend_vld_q[scan_q[QIW-1:0]]) begin
          state_d = ST_PS_CMP;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_PS_CMP: begin
        if (pd_rd_q.id == cmd_q.task_ref) begin
          pend_vld_d[scan_q[QIW-1:0]] = 1'b0;
          pend_cnt_d                  = pend_cnt_q - 1'b1;
          found_d                     = 1'b1;
        end
        scan_d  = scan_q + 1'b1;
        state_d = ST_PS_RD;
      end
      ST_RS_RD: begin
        if (32'(rscan_q) == RUN_SLOTS) begin
          state_d = ST_CL_A;
        end else if (run_vld_q[rscan_q[RIW-1:0]]) begin
          state_d = ST_RS_CMP;
        end else begin
          rscan_d = rscan_q + 1'b1;
        end
      end
      ST_RS_CMP: begin
        if (rm_rd_q == cmd_q.task_ref) begin
          run_vld_d[rscan_q[RIW-1:0]] = 1'b0;
          run_cnt_d                   = run_cnt_q - 1'b1;
          state_d                     = ST_CL_A;
        end else begin
          rscan_d = rscan_q + 1'b1;
          state_d = ST_RS_RD;
        end
      end
      ST_CL_A: begin
        state_d = ST_CL_B;
      end
      ST_CL_B: begin
        if (load != 5'd0) begin
          ld_we    = 1'b1;
          ld_wdata = load - 5'd1;
        end
        start_disp = 1'b1;
      end
      ST_DS_RD: begin
        if (32'(scan_q) == QUEUE_DEPTH) begin
          if (!best_vld_q || 32'(run_cnt_q) >= 32'(cfg_i.max_running)
              || 32'(run_cnt_q) == RUN_SLOTS) begin
            state_d = ST_RL_A;
          end else begin
            ld_addr_d = AW'(best_q.agent);
            state_d   = ST_DL_A;
          end
        end else if (pend_vld_q[scan_q[QIW-1:0]]) begin
          state_d = ST_DS_CMP;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_DS_CMP: begin
        // strict compare keeps the oldest among equal priority
        if (!best_vld_q || pd_rd_q.prio > best_q.prio
            || (pd_rd_q.prio == best_q.prio && age > best_age_q)) begin
          best_vld_d = 1'b1;
          best_idx_d = scan_q[QIW-1:0];
          best_d     = pd_rd_q;
          best_age_d = age;
        end
        scan_d  = scan_q + 1'b1;
        state_d = ST_DS_RD;
      end
      ST_DL_A: begin
        state_d = ST_DL_B;
      end
      ST_DL_B: begin
        if (load >= cfg_i.max_per_agent) begin
          state_d = ST_RL_A;
        end else if (!res_full_i) begin
          pend_vld_d[best_idx_q] = 1'b0;
          pend_cnt_d             = pend_cnt_q - 1'b1;
          rm_we                  = 1'b1;
          run_vld_d[rfree]       = 1'b1;
          run_cnt_d              = run_cnt_q + 1'b1;
          ld_we                  = 1'b1;
          ld_wdata               = sat5(16'(load) + 16'd1);
          ndisp_d                = ndisp_q + 1'b1;
          res_wr_o               = 1'b1;
          res_o.kind             = KIND_DISPATCH;
          res_o.out_task         = best_q.id;
          res_o.out_agent        = best_q.agent;
          res_o.paused_now       = pause_q;
          res_o.queued_count     = sat5(16'(pend_cnt_d));
          res_o.running_count    = sat5(16'(run_cnt_d));
          res_o.agent_running    = ld_wdata;
          if (32'(ndisp_q) == MaxDispatch - 1) begin
            state_d = ST_RL_A;
          end else begin
            scan_d     = '0;
            best_vld_d = 1'b0;
            state_d    = ST_DS_RD;
          end
        end
      end
      ST_RL_A: begin
        state_d = ST_RL_B;
      end
      ST_RL_B: begin
        if (!res_full_i) begin
          res_wr_o            = 1'b1;
          res_o.kind          = kind_q;
          res_o.out_task      = task_q;
          res_o.found         = found_q;
          res_o.paused_now    = pause_q;
          res_o.queued_count  = sat5(16'(pend_cnt_q));
          res_o.running_count = sat5(16'(run_cnt_q));
          res_o.agent_running = load;
          res_o.last          = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (start_disp) begin
      ndisp_d    = '0;
      scan_d     = '0;
      best_vld_d = 1'b0;
      state_d    = pause_d ? ST_RL_A : ST_DS_RD;
    end
    // the command's own agent load is read ahead of the complete update and the reply
    if (state_d == ST_RL_A || state_d == ST_CL_A) begin
      ld_addr_d = AW'(cmd_q.agent);
    end
    if (ld_we) begin
      ld_vld_d[ld_addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pd_we) begin
      pend_mem[pd_waddr] <= pd_wdata;
    end
    pd_rd_q <= pend_mem[scan_q[QIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rm_we) begin
      run_mem[rm_waddr] <= best_q.id;
    end
    rm_rd_q <= run_mem[rscan_q[RIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      ld_mem[ld_addr_q] <= ld_wdata;
    end
    ld_rd_q <= ld_mem[ld_addr_q];
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    task_q     <= task_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    best_age_q <= best_age_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_vld_q <= '0;
      run_vld_q  <= '0;
      ld_vld_q   <= '0;
      ld_vrd_q   <= 1'b0;
      pend_cnt_q <= '0;
      run_cnt_q  <= '0;
      next_id_q  <= '0;
      pause_q    <= 1'b0;
      kind_q     <= KIND_REPLY;
      found_q    <= 1'b0;
      scan_q     <= '0;
      rscan_q    <= '0;
      ld_addr_q  <= '0;
      ndisp_q    <= '0;
      best_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      run_vld_q  <= run_vld_d;
      ld_vld_q   <= ld_vld_d;
      ld_vrd_q   <= ld_vld_q[ld_addr_q];
      pend_cnt_q <= pend_cnt_d;
      run_cnt_q  <= run_cnt_d;
      next_id_q  <= next_id_d;
      pause_q    <= pause_d;
      kind_q     <= kind_d;
      found_q    <= found_d;
      scan_q     <= scan_d;
      rscan_q    <= rscan_d;
      ld_addr_q  <= ld_addr_d;
      ndisp_q    <= ndisp_d;
      best_vld_q <= best_vld_d;
    end
  end

endmodule

// File: sv/priority_task_dispatcher.sv
// A status, pause or unknown command goes straight to the reply. Each pending-queue
// scan (cancel, each dispatch attempt) skips free entries and reads and compares valid
// ones; each dispatch then reads the agent load; complete searches the run slots the
// same way, stopping on a hit, and then updates the agent load before dispatch.
// Throughput: one command at a time in the back end; 2-entry command and result
// queues decouple the ports. Async active-low reset clears control state and valid bits, limits 4 and 2.
module priority_task_dispatcher
  import pdq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned RUN_SLOTS   = RunSlotsDef,
  parameter int unsigned NUM_AGENTS  = NumAgentsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  item_t      item_i,
  output logic       empty,
  input  logic       pop,
  output result_t    result_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    avail, deq;
  cmd_t    cmd;
  logic    res_wr, res_full;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_running   <= 5'd4;
      cfg_q.max_per_agent <= 5'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_RUNNING:   cfg_q.max_running   <= cfg_data_i;
        CFG_MAX_PER_AGENT: cfg_q.max_per_agent <= cfg_data_i;
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  pdq_front #(
    .NUM_AGENTS(NUM_AGENTS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .item_i (item_i),
    .deq_i  (deq),
    .avail_o(avail),
    .cmd_o  (cmd)
  );

  pdq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .RUN_SLOTS  (RUN_SLOTS),
    .NUM_AGENTS (NUM_AGENTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .avail_i   (avail),
    .cmd_i     (cmd),
    .deq_o     (deq),
    .res_wr_o  (res_wr),
    .res_o     (res),
    .res_full_i(res_full)
  );

  pdq_rfifo u_rfifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_wr),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (result_o)
  );

  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_wr && res_full))
    else $error("result written while result queue full");

  a_deq_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq |-> avail)
    else $error("command taken from empty command queue");

  a_reject_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.kind == KIND_REJECT) |-> (result_o.out_task == 16'd0))
    else $error("rejected submit carries an id");

  a_disp_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.kind == KIND_DISPATCH) |->
      (!result_o.last && !result_o.paused_now && !result_o.found))
    else $error("malformed dispatch transaction");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pdq_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned SLOTS = 16;
  localparam int unsigned AGENTS = 16;
  localparam int unsigned DISPATCH_CAP = 16;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  item_t item_i;
  logic empty;
  logic pop;
  result_t result_o;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [4:0] cfg_data_i;

  priority_task_dispatcher dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .item_i(item_i),
    .empty(empty),
    .pop(pop),
    .result_o(result_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scheduler mirror
  logic [4:0] lim_running;
  logic [4:0] lim_agent;
  logic q_valid [QDEPTH];
  logic [15:0] q_id [QDEPTH];
  logic [3:0] q_agent [QDEPTH];
  logic [1:0] q_prio [QDEPTH];
  logic r_valid [SLOTS];
  logic [15:0] r_id [SLOTS];
  logic [4:0] load [AGENTS];
  logic [15:0] id_ctr;
  logic paused;

  // table reply to check against the predicted reply of accepted transaction idx
  typedef struct {
    int idx;
    int row;
    result_t reply;
  } chk_t;

  result_t pending_results[$];
  chk_t chk_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  bit stall_go = 0;
  int quiet = 0;
  int sent = 0;
  int acc_cnt = 0;

  function automatic logic [4:0] q_count();
    int n = 0;
    for (int i = 0; i < QDEPTH; i++) n += q_valid[i];
    return (n > 31) ? 5'd31 : 5'(n);
  endfunction

  function automatic logic [4:0] r_count();
    int n = 0;
    for (int i = 0; i < SLOTS; i++) n += r_valid[i];
    return (n > 31) ? 5'd31 : 5'(n);
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [15:0] tsk, logic [3:0] ag,
                                     logic fnd, logic [4:0] aload, logic lst);
    result_t r;
    r.kind = kind;
    r.out_task = tsk;
    r.out_agent = ag;
    r.found = fnd;
    r.paused_now = paused;
    r.queued_count = q_count();
    r.running_count = r_count();
    r.agent_running = aload;
    r.last = lst;
    pending_results = {pending_results, r};
  endfunction

  function automatic void run_dispatch();
    int best;
    int slot;
    logic [15:0] best_age;
    logic [15:0] age;
    logic [3:0] ag;
    if (paused) return;
    for (int d = 0; d < DISPATCH_CAP; d++) begin
      best = -1;
      best_age = '0;
      for (int i = 0; i < QDEPTH; i++) begin
        if (!q_valid[i]) continue;
        age = id_ctr - q_id[i];
        if (best < 0 || q_prio[i] > q_prio[best] ||
            (q_prio[i] == q_prio[best] && age > best_age)) begin
          best = i;
          best_age = age;
        end
      end
      if (best < 0) return;
      if (r_count() >= lim_running) return;
      slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--) if (!r_valid[i]) slot = i;
      if (slot < 0) return;
      ag = q_agent[best];
      if (load[ag] >= lim_agent) return;
      q_valid[best] = 1'b0;
      r_valid[slot] = 1'b1;
      r_id[slot] = q_id[best];
      if (load[ag] != 5'd31) load[ag] = load[ag] + 5'd1;
      add_result(KIND_DISPATCH, q_id[best], ag, 1'b0, load[ag], 1'b0);
    end
  endfunction

  function automatic void predict_command(item_t it);
    logic [1:0] kind = KIND_REPLY;
    logic [15:0] tsk = '0;
    logic fnd = 1'b0;
    int slot = -1;
    case (it.command)
      CMD_SUBMIT: begin
        for (int i = QDEPTH - 1; i >= 0; i--) if (!q_valid[i]) slot = i;
        if (slot < 0) begin
          kind = KIND_REJECT;
        end else begin
          q_valid[slot] = 1'b1;
          q_id[slot] = id_ctr;
          q_agent[slot] = it.agent;
          q_prio[slot] = it.prio;
          tsk = id_ctr;
          id_ctr = id_ctr + 16'd1;
        end
        run_dispatch();
      end
      CMD_COMPLETE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (r_valid[i] && r_id[i] == it.task_ref) begin
            r_valid[i] = 1'b0;
            break;
          end
        end
        if (load[it.agent] != 0) load[it.agent] = load[it.agent] - 5'd1;
        run_dispatch();
      end
      CMD_CANCEL: begin
        for (int i = 0; i < QDEPTH; i++) begin
          if (q_valid[i] && q_id[i] == it.task_ref) begin
            q_valid[i] = 1'b0;
            fnd = 1'b1;
          end
        end
      end
      CMD_PAUSE: paused = 1'b1;
      CMD_RESUME: begin
        paused = 1'b0;
        run_dispatch();
      end
      default: ;
    endcase
    add_result(kind, tsk, 4'd0, fnd, load[it.agent], 1'b1);
  endfunction

  // transaction monitor and scoreboard
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet <= 0;
      else quiet <= quiet + 1;
      if (push && !full) begin
        predict_command(item_i);
        if (chk_q.size() != 0 && chk_q[0].idx == acc_cnt) begin
          if (pending_results[$] != chk_q[0].reply) begin
            $error("reply table mismatch row %0d: exp %p got %p", chk_q[0].row,
                   chk_q[0].reply, pending_results[$]);
            errors++;
          end
          void'(chk_q.pop_front());
        end
        acc_cnt++;
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result %p", result_o);
          errors++;
          $display("[priority_task_dispatcher] ERROR");
          $finish;
        end else begin
          exp_r = pending_results.pop_front();
          if (result_o.kind !== exp_r.kind) begin
            $error("kind exp %0d got %0d", exp_r.kind, result_o.kind); errors++;
          end
          if (result_o.out_task !== exp_r.out_task) begin
            $error("out_task exp %0d got %0d", exp_r.out_task, result_o.out_task); errors++;
          end
          if (result_o.out_agent !== exp_r.out_agent) begin
            $error("out_agent exp %0d got %0d", exp_r.out_agent, result_o.out_agent);
            errors++;
          end
          if (result_o.found !== exp_r.found) begin
            $error("found exp %0d got %0d", exp_r.found, result_o.found); errors++;
          end
          if (result_o.paused_now !== exp_r.paused_now) begin
            $error("paused_now exp %0d got %0d", exp_r.paused_now, result_o.paused_now);
            errors++;
          end
          if (result_o.queued_count !== exp_r.queued_count) begin
            $error("queued_count exp %0d got %0d", exp_r.queued_count,
                   result_o.queued_count);
            errors++;
          end
          if (result_o.running_count !== exp_r.running_count) begin
            $error("running_count exp %0d got %0d", exp_r.running_count,
                   result_o.running_count);
            errors++;
          end
          if (result_o.agent_running !== exp_r.agent_running) begin
            $error("agent_running exp %0d got %0d", exp_r.agent_running,
                   result_o.agent_running);
            errors++;
          end
          if (result_o.last !== exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, result_o.last); errors++;
          end
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && quiet >= STALL_LIMIT) begin
      $display("[priority_task_dispatcher] ERROR");
      $finish;
    end
  end

  task automatic send(item_t it);
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      item_i <= item_t'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic go_idle();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [4:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_RUNNING) lim_running = val;
    else lim_agent = val;
  endtask

  function automatic item_t mk(cmd_e c, logic [15:0] r, logic [3:0] a, logic [1:0] p);
    item_t it;
    it.command = c;
    it.task_ref = r;
    it.agent = a;
    it.prio = p;
    return it;
  endfunction

  // random command, biased toward realistic traffic
  function automatic item_t rand_item();
    item_t it;
    int pick = $urandom_range(99);
    int n = 0;
    logic [15:0] ids [$];
    it = item_t'($urandom);
    if (pick < 40) it.command = CMD_SUBMIT;
    else if (pick < 70) begin
      it.command = CMD_COMPLETE;
      for (int i = 0; i < SLOTS; i++) if (r_valid[i]) ids = {ids, r_id[i]};
      n = ids.size();
      if (n > 0 && $urandom_range(9) < 8) it.task_ref = ids[$urandom_range(n - 1)];
    end else if (pick < 80) begin
      it.command = CMD_CANCEL;
      for (int i = 0; i < QDEPTH; i++) if (q_valid[i]) ids = {ids, q_id[i]};
      n = ids.size();
      if (n > 0 && $urandom_range(9) < 6) it.task_ref = ids[$urandom_range(n - 1)];
    end else if (pick < 85) it.command = CMD_PAUSE;
    else if (pick < 92) it.command = CMD_RESUME;
    else if (pick < 97) it.command = CMD_STATUS;
    else it.command = 3'($urandom_range(6, 7));
    return it;
  endfunction

  // directed rows: expected reply given where known, otherwise predicted
  typedef struct {
    item_t it;
    bit known;
    result_t reply;
  } row_t;

  initial begin
    row_t rows [$];
    row_t rw;
    chk_t ck;
    rst_ni = 1'b0;
    push = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MAX_RUNNING;
    cfg_data_i = '0;
    lim_running = 5'd4;
    lim_agent = 5'd2;
    for (int i = 0; i < QDEPTH; i++) begin
      q_valid[i] = 0; q_id[i] = '0; q_agent[i] = '0; q_prio[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      r_valid[i] = 0; r_id[i] = '0;
    end
    for (int i = 0; i < AGENTS; i++) load[i] = '0;
    id_ctr = '0;
    paused = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // status after reset, then pause/resume, a cancel and unknown commands
    rw.known = 1;
    rw.it = mk(CMD_STATUS, 16'hFFFF, 4'hF, 2'd3);
    rw.reply = '{kind: KIND_REPLY, out_task: 0, out_agent: 0, found: 0, paused_now: 0,
                 queued_count: 0, running_count: 0, agent_running: 0, last: 1};
    rows = {rows, rw};
    rw.it = mk(CMD_PAUSE, 0, 0, 0);
    rw.reply.paused_now = 1;
    rows = {rows, rw};
    rw.it = mk(cmd_e'(3'd7), 16'hFFFF, 4'hF, 2'd3);
    rows = {rows, rw};
    rw.it = mk(CMD_CANCEL, 16'h1234, 0, 0);
    rows = {rows, rw};
    rw.it = mk(cmd_e'(3'd6), 0, 0, 0);
    rows = {rows, rw};
    rw.it = mk(CMD_RESUME, 0, 0, 0);
    rw.reply.paused_now = 0;
    rows = {rows, rw};
    rw.known = 0;
    // equal prio ties and priorities, same agent to hit the per-agent limit
    for (int i = 0; i < 6; i++) begin
      rw.it = mk(CMD_SUBMIT, 16'hFFFF, 4'd3, 2'(i % 4));
      rows = {rows, rw};
    end
    rw.it = mk(CMD_COMPLETE, 16'd0, 4'd3, 0);
    rows = {rows, rw};
    rw.it = mk(CMD_CANCEL, 16'd5, 4'd3, 0);
    rows = {rows, rw};
    rw.it = mk(CMD_COMPLETE, 16'hFFFF, 4'd0, 0);
    rows = {rows, rw};
    for (int i = 0; i < 12; i++) begin
      rw.it = mk(CMD_SUBMIT, 0, 4'(i), 2'd3);
      rows = {rows, rw};
    end
    rw.it = mk(CMD_STATUS, 0, 4'd3, 0);
    rows = {rows, rw};

    send_idle_pct = 31;
    recv_idle_pct = 45;
    foreach (rows[i]) begin
      if (rows[i].known) begin
        ck.idx = sent;
        ck.row = i;
        ck.reply = rows[i].reply;
        chk_q = {chk_q, ck};
      end
      send(rows[i].it);
    end
    go_idle();

    // extreme limits: zero running or zero per-agent limit blocks all dispatch, then maximum running
    write_cfg(CFG_MAX_RUNNING, 5'd0);
    write_cfg(CFG_MAX_PER_AGENT, 5'd31);
    for (int i = 0; i < 4; i++) send(mk(CMD_RESUME, 0, 4'(i), 0));
    go_idle();
    write_cfg(CFG_MAX_RUNNING, 5'd31);
    write_cfg(CFG_MAX_PER_AGENT, 5'd0);
    send(mk(CMD_RESUME, 0, 0, 0));
    go_idle();
    write_cfg(CFG_MAX_PER_AGENT, 5'd16);
    send(mk(CMD_RESUME, 0, 0, 0));
    go_idle();

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 31 : 0;
      write_cfg(CFG_MAX_RUNNING, 5'($urandom_range(1, 16)));
      write_cfg(CFG_MAX_PER_AGENT, 5'($urandom_range(1, 16)));
      for (int n = 0; n < 150; n++) begin
        if (ph == 1 && n == 40) stall_go = 1'b1;
        send(rand_item());
      end
      go_idle();
    end

    if (errors == 0) begin
      $display("[priority_task_dispatcher] OK");
    end else begin
      $display("[priority_task_dispatcher] ERROR");
    end
    $finish;
  end

  // long receiver stall counted in its own process
  initial begin
    wait (stall_go);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

endmodule
